// ===== sv/ert_pkg.sv =====
// Package for the echo reply tracker: payload structs, codes and constants.
// Used by the channel interfaces, ert_front, ert_back and the top level.
package ert_pkg;

    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_REPLY  = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_NEW     = 2'd1,
        ST_DUP     = 2'd2,
        ST_UNUSED  = 2'd3
    } t_status;

    localparam logic [2:0] REG_ECHO_ID     = 3'd0;
    localparam logic [2:0] REG_PAYLOAD_LEN = 3'd1;
    localparam logic [2:0] REG_PING_COUNT  = 3'd2;
    localparam logic [2:0] REG_INTERVAL    = 3'd3;
    localparam logic [2:0] REG_TIMEOUT     = 3'd4;

    localparam int          CFG_W         = 32;
    localparam int          CFG_IDX_W     = 3;
    localparam logic [31:0] ALL32         = 32'hFFFF_FFFF;
    localparam logic [31:0] USEC_PER_SEC  = 32'd1000000;
    localparam logic [11:0] ECHO_HDR      = 12'd8;
    localparam logic [10:0] STAMP_BYTES   = 11'd4;
    localparam logic [6:0]  PERCENT       = 7'd100;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] reply_size;
        logic [7:0]  reply_type;
        logic [15:0] reply_id;
        logic [15:0] reply_seq;
        logic [31:0] stamp_us;
        logic [31:0] now_us;
    } t_req;

    typedef struct packed {
        logic [15:0] seq_sent;
        logic [31:0] timer_us;
        logic        timer_finishes;
        logic [1:0]  reply_status;
        logic [31:0] rtt_us;
        logic [31:0] sent_total;
        logic [31:0] received_total;
        logic [31:0] duplicate_total;
        logic [6:0]  loss_percent;
        logic [31:0] rtt_min_us;
        logic [31:0] rtt_avg_us;
        logic [31:0] rtt_max_us;
    } t_rsp;

    // classified request handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        accept;   // reply passes size/type/id checks
        logic        timed;
        logic [15:0] seq;
        logic [31:0] rtt;
    } t_cmd;

endpackage

// ===== sv/ert_req_if.sv =====
// Request channel interface of the echo reply tracker.
// Depends on ert_pkg.
interface ert_req_if import ert_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ert_rsp_if.sv =====
// Result channel interface of the echo reply tracker.
// Depends on ert_pkg.
interface ert_rsp_if import ert_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ert_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ert_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/ert_front.sv =====
// Front end: accepts requests, checks replies, computes round trip.
// Depends on ert_pkg; feeds a two-entry queue toward ert_back.
module ert_front import ert_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ert_req_if.sink      req,
    input  logic [15:0]  i_echo_id,
    input  logic [10:0]  i_payload_len,
    output logic         o_cmd_valid,
    output t_cmd         o_cmd,
    input  logic         i_cmd_pop
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    t_cmd       n_cmd;
    logic       push;

    assign req.ready   = (r_cnt != 2'd2);
    assign push        = req.valid && req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // classify the incoming request
    always_comb begin
        n_cmd.kind   = t_kind'(req.data.kind);
        n_cmd.accept = ({1'b0, req.data.reply_size} >= {6'd0, i_payload_len} + {5'd0, ECHO_HDR})
                       && (req.data.reply_type == 8'd0) && (req.data.reply_id == i_echo_id);
        n_cmd.timed  = (i_payload_len >= STAMP_BYTES);
        n_cmd.seq    = req.data.reply_seq;
        n_cmd.rtt    = n_cmd.timed ? (req.data.now_us - req.data.stamp_us) : 32'd0;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !i_cmd_pop |=> r_cnt == 2'd2) else $error("full queue lost entry");
`endif
endmodule

// ===== sv/ert_div.sv =====
// Serial restoring divider, 64-bit dividend by 33-bit divisor, one bit a cycle.
// Depends on nothing; used by ert_back for loss and average.
module ert_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quo
);
    logic [63:0] r_quo;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic [33:0] trial;
    logic [34:0] diff;

    assign o_busy = (r_cnt != 7'd0);
    assign o_quo  = r_quo;
    assign trial  = {r_rem[32:0], r_quo[63]};
    assign diff   = {1'b0, trial} - {2'b0, r_den};

    // shift in one dividend bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (i_start) begin
            r_cnt <= 7'd64;
            r_quo <= i_num;
            r_rem <= 34'd0;
            r_den <= i_den;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (!diff[34]) begin
                r_rem <= diff[33:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end
endmodule

// ===== sv/ert_back.sv =====
// Back end: seen map read-modify-write, counters, timers and report division.
// Depends on ert_pkg, ert_ram and ert_div.
module ert_back import ert_pkg::*; #(
    parameter int TRACK_BITS = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cmd_valid,
    input  t_cmd         i_cmd,
    output logic         o_cmd_pop,
    input  logic [15:0]  i_ping_count,
    input  logic [31:0]  i_interval_us,
    input  logic [31:0]  i_timeout_us,
    ert_rsp_if.source    rsp
);
    localparam int AW = $clog2(TRACK_BITS);
    localparam int CW = (AW > 16) ? AW : 16;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_UPD, S_DIV1, S_DIV2, S_OUT
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic [31:0]   r_sent, r_recv, r_dup, r_least, r_most;
    logic [63:0]   r_sum;
    logic          r_ok;
    logic [6:0]    r_loss;
    t_rsp          r_rsp;
    t_rsp          r_work;
    logic          r_valid;
    logic [AW-1:0] r_clr;

    t_rsp          n_work;
    t_rsp          n_rsp;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic          wdata, rdata;
    logic          div_start, div_busy;
    logic [63:0]   div_num, div_quo;
    logic [32:0]   div_den;
    logic [63:0]   sum_add;
    logic [32:0]   cnt;
    logic [32:0]   sent_p1;
    logic [12:0]   secs;
    logic [51:0]   fin_t;
    logic [31:0]   fin_timer;

    assign rsp.valid = r_valid;
    assign rsp.data  = r_rsp;
    assign raddr     = AW'(CW'(r_cmd.seq));
    assign cnt       = {1'b0, r_recv} + {1'b0, r_dup};
    assign sent_p1   = {1'b0, r_sent} + 33'd1;
    assign sum_add   = r_sum + {32'd0, r_cmd.rtt};
    assign secs      = r_most[31:19];
    assign fin_t     = {39'd0, secs} * {20'd0, USEC_PER_SEC};
    assign fin_timer = (fin_t[51:32] != 20'd0) ? ALL32 :
                       (fin_t[31:0] == 32'd0) ? USEC_PER_SEC : fin_t[31:0];

    ert_ram #(.WIDTH(1), .DEPTH(TRACK_BITS)) u_seen (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    ert_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num), .i_den(div_den),
        .o_busy(div_busy), .o_quo(div_quo)
    );

    // seen map write and divider launch
    always_comb begin
        we        = 1'b0;
        waddr     = AW'(CW'(r_sent[15:0]));
        wdata     = 1'b0;
        div_start = 1'b0;
        div_num   = {32'd0, r_sent - r_recv} * 64'd100;
        div_den   = {1'b0, r_sent};
        if (r_state == S_CLEAR) begin
            we = 1'b1; waddr = r_clr;
        end else if (r_state == S_UPD && r_cmd.kind == KIND_SEND) begin
            we = 1'b1;
        end else if (r_state == S_UPD && r_cmd.kind == KIND_REPLY && r_cmd.accept
                     && !rdata) begin
            we = 1'b1; waddr = raddr; wdata = 1'b1;
        end
        if (r_state == S_READ && r_cmd.kind == KIND_REPORT) div_start = 1'b1;
        if (r_state == S_DIV1 && !div_busy) begin
            div_start = 1'b1;
            div_num   = r_sum;
            div_den   = cnt;
        end
    end

    // build the per-kind fields, then add the totals on the way out
    always_comb begin
        n_work = r_work;
        if (r_state == S_UPD) begin
            n_work = '0;
            if (r_cmd.kind == KIND_SEND) begin
                n_work.seq_sent = r_sent[15:0];
                if (sent_p1 < {17'd0, i_ping_count}) begin
                    n_work.timer_us = i_interval_us;
                end else begin
                    n_work.timer_finishes = 1'b1;
                    n_work.timer_us = (r_recv != 32'd0) ? fin_timer : i_timeout_us;
                end
            end else if (r_cmd.kind == KIND_REPLY && r_cmd.accept) begin
                n_work.rtt_us       = r_cmd.rtt;
                n_work.reply_status = rdata ? ST_DUP : ST_NEW;
            end
        end else if (r_state == S_DIV2 && !div_busy) begin
            n_work = '0;
            n_work.loss_percent = r_loss;
            n_work.rtt_avg_us   = !r_ok ? 32'd0 :
                (div_quo[63:32] != 32'd0) ? ALL32 : div_quo[31:0];
        end
        n_rsp                 = r_work;
        n_rsp.sent_total      = r_sent;
        n_rsp.received_total  = r_recv;
        n_rsp.duplicate_total = r_dup;
        n_rsp.rtt_min_us      = r_least;
        n_rsp.rtt_max_us      = r_most;
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // sequencer, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_sent  <= 32'd0;
            r_recv  <= 32'd0;
            r_dup   <= 32'd0;
            r_sum   <= 64'd0;
            r_least <= ALL32;
            r_most  <= 32'd0;
        end else begin
            // load the result register only once the previous one is taken
            if (r_state == S_OUT && (!r_valid || rsp.ready)) begin
                r_valid <= 1'b1;
                r_rsp   <= n_rsp;
            end else if (rsp.valid && rsp.ready) begin
                r_valid <= 1'b0;
            end
            r_work <= n_work;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TRACK_BITS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_ok <= (r_sent != 32'd0) && (r_recv < r_sent);
                    r_state <= (r_cmd.kind == KIND_REPORT) ? S_DIV1 : S_UPD;
                end
                S_UPD: begin
                    unique case (r_cmd.kind)
                        KIND_SEND: begin
                            if (r_sent != ALL32) r_sent <= r_sent + 32'd1;
                        end
                        KIND_REPLY: begin
                            if (r_cmd.accept) begin
                                if (r_cmd.timed) begin
                                    r_sum <= (sum_add < r_sum) ? '1 : sum_add;
                                    if (r_cmd.rtt < r_least) r_least <= r_cmd.rtt;
                                    if (r_cmd.rtt > r_most) r_most <= r_cmd.rtt;
                                end
                                if (rdata) begin
                                    if (r_dup != ALL32) r_dup <= r_dup + 32'd1;
                                end else begin
                                    if (r_recv != ALL32) r_recv <= r_recv + 32'd1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_DIV1: begin
                    if (!div_busy) begin
                        r_loss  <= r_ok ? div_quo[6:0] : 7'd0;
                        r_ok    <= (r_least != ALL32) && (cnt != 33'd0);
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (!div_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_valid || rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_state == S_READ) else $error("pop without load");
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_least != ALL32 |-> r_least <= r_most) else $error("min above max");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> r_state == S_DIV1 || r_state == S_DIV2) else $error("stray divide");
`endif
endmodule

// ===== sv/echo_reply_tracker.sv =====
// Top level of the echo reply tracker: configuration registers, front, back.
// Depends on ert_pkg, ert_req_if, ert_rsp_if, ert_front, ert_back.
//
//  channel | dir | payload
//  req     | in  | kind, reply fields, stamp and arrival time
//  rsp     | out | send, reply, report fields and totals
//  cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// Send and reply requests pass the back end as queue pop, map read, update and
// result register; the registered seen map read needs its own read state.
// Reports run two serial divisions, loss then average, before the result.
// After reset the back end clears all TRACK_BITS (default 512) seen map entries.
// The front queue holds two requests; a stalled result blocks input once it fills.
module echo_reply_tracker import ert_pkg::*; #(
    parameter int TRACK_BITS = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ert_req_if.sink              req,
    ert_rsp_if.source            rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    logic [15:0] r_echo_id, r_ping_count;
    logic [10:0] r_payload_len;
    logic [31:0] r_interval, r_timeout;
    logic        cmd_valid, cmd_pop;
    t_cmd        cmd;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_id     <= 16'd83;
            r_payload_len <= 11'd4;
            r_ping_count  <= 16'd3;
            r_interval    <= 32'd1000000;
            r_timeout     <= 32'd1000000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ECHO_ID:     r_echo_id     <= i_cfg_data[15:0];
                REG_PAYLOAD_LEN: r_payload_len <= i_cfg_data[10:0];
                REG_PING_COUNT:  r_ping_count  <= i_cfg_data[15:0];
                REG_INTERVAL:    r_interval    <= i_cfg_data;
                REG_TIMEOUT:     r_timeout     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ert_front u_front (
        .i_clk, .i_rst_n, .req,
        .i_echo_id(r_echo_id), .i_payload_len(r_payload_len),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    ert_back #(.TRACK_BITS(TRACK_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_pop(cmd_pop),
        .i_ping_count(r_ping_count), .i_interval_us(r_interval),
        .i_timeout_us(r_timeout), .rsp
    );
endmodule
